### hdl/u8cv_pkg.sv
// ----------------------------------------------------------------------------
// u8cv_pkg
// Shared types, constants and helpers of the UTF-8 string validator.
// ----------------------------------------------------------------------------
package u8cv_pkg;

  localparam int unsigned CntW  = 9;
  localparam int unsigned RegW  = 8;
  localparam int unsigned AccW  = 16;

  localparam logic [CntW-1:0] CntMax        = 9'd256;
  localparam logic [RegW-1:0] MaxBytesReset = 8'd90;
  localparam logic [RegW-1:0] MaxCharsReset = 8'd30;

  localparam logic [AccW-1:0] HangulFirst = 16'hAC00;
  localparam logic [AccW-1:0] HangulLast  = 16'hD7A3;

  // sequence length codes
  localparam logic [1:0] SeqNone  = 2'd0;
  localparam logic [1:0] SeqOne   = 2'd1;
  localparam logic [1:0] SeqTwo   = 2'd2;
  localparam logic [1:0] SeqThree = 2'd3;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_MAX_BYTES = 1'b0,
    REG_MAX_CHARS = 1'b1
  } cfg_reg_t;

  // per-string decode state
  typedef struct packed {
    logic [1:0]      bytes_pending;
    logic [AccW-1:0] code_acc;
    logic [1:0]      seq_len;
    logic [CntW-1:0] byte_cnt;
    logic [CntW-1:0] char_cnt;
    logic            bad;
  } str_state_t;

  localparam str_state_t StrStateClear = '{
    bytes_pending: 2'd0,
    code_acc:      '0,
    seq_len:       SeqNone,
    byte_cnt:      '0,
    char_cnt:      '0,
    bad:           1'b0
  };

  function automatic logic char_allowed(input logic [AccW-1:0] cp, input logic [1:0] len);
    logic res;
    res = 1'b0;
    if (len == SeqOne) begin
      res = (cp >= 16'h0061 && cp <= 16'h007A) || (cp >= 16'h0041 && cp <= 16'h005A) ||
            (cp >= 16'h0030 && cp <= 16'h0039);
    end else if (len == SeqThree) begin
      res = (cp >= HangulFirst) && (cp <= HangulLast);
    end
    return res;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v < CntMax) ? v + CntW'(1) : v;
  endfunction

endpackage

### hdl/u8cv_if.sv
// ----------------------------------------------------------------------------
// u8cv channels
// Valid/ready channels for string bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface u8cv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface u8cv_result_if;
  logic valid;
  logic ready;
  logic string_ok;

  modport source (output valid, output string_ok, input ready);
  modport sink   (input valid, input string_ok, output ready);
endinterface

### hdl/utf8_charclass_validator_unit.sv
// ----------------------------------------------------------------------------
// utf8_charclass_validator_unit
// Streaming UTF-8 string checker with character class and length limits.
// ----------------------------------------------------------------------------
// Takes one string byte per clock and, on the byte flagged last, delivers one
// verdict: 1 when the string is strict UTF-8 of one to three byte sequences,
// every character is an ASCII letter, an ASCII digit or a Hangul syllable,
// and the byte and character counts are within max_bytes (index 0) and
// max_chars (index 1). Each byte is decoded in the cycle it is accepted and
// the verdict is in the output register in the next cycle; a new byte is
// taken every clock unless a verdict is held waiting for the sink. Limits are
// sampled on the last byte; write them only while no string is in flight.
// ----------------------------------------------------------------------------
module utf8_charclass_validator_unit
  import u8cv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [RegW-1:0]     cfg_data,
  u8cv_byte_if.sink           byte_in,
  u8cv_result_if.source       result_out
);

  logic [RegW-1:0] max_bytes;
  logic [RegW-1:0] max_chars;
  str_state_t      str_state;
  str_state_t      str_state_next;
  logic            step_ok;
  logic            out_valid;
  logic            out_ok;
  logic            accept;

  // hold the input only while a verdict waits for the sink
  assign byte_in.ready        = !out_valid || result_out.ready;
  assign accept               = byte_in.valid && byte_in.ready;
  assign result_out.valid     = out_valid;
  assign result_out.string_ok = out_ok;

  u8cv_step u_step (
    .cur        (str_state),
    .byte_value (byte_in.byte_value),
    .last_byte  (byte_in.last_byte),
    .max_bytes  (max_bytes),
    .max_chars  (max_chars),
    .nxt        (str_state_next),
    .string_ok  (step_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MaxBytesReset;
      max_chars <= MaxCharsReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_BYTES: max_bytes <= cfg_data;
        REG_MAX_CHARS: max_chars <= cfg_data;
        default:       max_bytes <= max_bytes;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      str_state <= StrStateClear;
      out_valid <= 1'b0;
    end else begin
      if (accept) str_state <= str_state_next;
      if (accept && byte_in.last_byte) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_in.last_byte) out_ok <= step_ok;
  end

endmodule

### hdl/u8cv_step.sv
// ----------------------------------------------------------------------------
// u8cv_step
// One byte of UTF-8 decode: next string state and the verdict on a last byte.
// ----------------------------------------------------------------------------
module u8cv_step
  import u8cv_pkg::*;
(
  input  str_state_t      cur,
  input  logic [7:0]      byte_value,
  input  logic            last_byte,
  input  logic [RegW-1:0] max_bytes,
  input  logic [RegW-1:0] max_chars,
  output str_state_t      nxt,
  output logic            string_ok
);

  str_state_t upd;
  logic       finish;

  always_comb begin
    upd          = cur;
    finish       = 1'b0;
    upd.byte_cnt = sat_inc(cur.byte_cnt);

    if (cur.bytes_pending == 2'd0) begin
      priority if (!byte_value[7]) begin
        upd.code_acc = {8'h00, byte_value};
        upd.seq_len  = SeqOne;
        finish       = 1'b1;
      end else if (byte_value[7:5] == 3'b110) begin
        upd.code_acc      = {11'd0, byte_value[4:0]};
        upd.seq_len       = SeqTwo;
        upd.bytes_pending = 2'd1;
      end else if (byte_value[7:4] == 4'b1110) begin
        upd.code_acc      = {12'd0, byte_value[3:0]};
        upd.seq_len       = SeqThree;
        upd.bytes_pending = 2'd2;
      end else begin
        upd.bad = 1'b1;
      end
    end else if (byte_value[7:6] != 2'b10) begin
      // broken sequence: drop it and restart at the next byte
      upd.bad           = 1'b1;
      upd.bytes_pending = 2'd0;
      upd.code_acc      = '0;
      upd.seq_len       = SeqNone;
    end else begin
      upd.code_acc      = {cur.code_acc[AccW-7:0], byte_value[5:0]};
      upd.bytes_pending = cur.bytes_pending - 2'd1;
      finish            = (cur.bytes_pending == 2'd1);
    end

    if (finish) begin
      if (!char_allowed(upd.code_acc, upd.seq_len)) upd.bad = 1'b1;
      upd.char_cnt = sat_inc(cur.char_cnt);
      upd.code_acc = '0;
      upd.seq_len  = SeqNone;
    end

    string_ok = !upd.bad && (upd.bytes_pending == 2'd0) && (upd.char_cnt != '0) &&
                (upd.byte_cnt <= {1'b0, max_bytes}) && (upd.char_cnt <= {1'b0, max_chars});
    nxt = last_byte ? StrStateClear : upd;
  end

endmodule

### tb/sv/utf8_charclass_validator_unit_tb.sv
// ----------------------------------------------------------------------------
// utf8_charclass_validator_unit_tb
// Self-checking bench for the streaming UTF-8 string checker.
// ----------------------------------------------------------------------------
// Sends strings one byte per item and checks every verdict against a
// cycle-free model of the decoder and of its byte and character limits, save
// those of a short hand-written table, which are typed in. The table covers
// the boundary code points, bad lead and continuation bytes, two-byte forms
// and unfinished sequences. Random strings follow, mostly clean with some
// noise, under several limit settings between zero and the maximum, with
// random idle cycles on both channels and one long hold on the verdict side.
// ----------------------------------------------------------------------------
module utf8_charclass_validator_unit_tb;
  import u8cv_pkg::*;

  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned DrainLimit   = 5000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned NumRows      = 24;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
    logic       ok;
  } dir_row_t;

  // verdicts typed in on the final byte of each string
  localparam dir_row_t DirRows [NumRows] = '{
    '{8'h41, 1'b1, 1'b1},
    '{8'h7A, 1'b0, 1'b0}, '{8'h30, 1'b1, 1'b1},
    '{8'h40, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b0},
    '{8'hEA, 1'b0, 1'b0}, '{8'hB0, 1'b0, 1'b0}, '{8'h80, 1'b1, 1'b1},
    '{8'hED, 1'b0, 1'b0}, '{8'h9E, 1'b0, 1'b0}, '{8'hA3, 1'b1, 1'b1},
    '{8'hED, 1'b0, 1'b0}, '{8'h9E, 1'b0, 1'b0}, '{8'hA4, 1'b1, 1'b0},
    '{8'hC3, 1'b0, 1'b0}, '{8'hA9, 1'b1, 1'b0},
    '{8'h80, 1'b1, 1'b0},
    '{8'hFF, 1'b1, 1'b0},
    '{8'hF0, 1'b0, 1'b0}, '{8'h41, 1'b1, 1'b0},
    '{8'hEA, 1'b0, 1'b0}, '{8'h41, 1'b1, 1'b0},
    '{8'hEA, 1'b0, 1'b0}, '{8'hB0, 1'b1, 1'b0}
  };

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_we;
  logic [0:0]      cfg_index;
  logic [RegW-1:0] cfg_data;

  u8cv_byte_if   byte_in();
  u8cv_result_if result_out();

  utf8_charclass_validator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_in   (byte_in),
    .result_out(result_out)
  );

  // decoder state of the string in flight
  logic [1:0]      pend       = 2'd0;
  logic [AccW-1:0] acc        = '0;
  logic [1:0]      seqlen     = SeqNone;
  logic [CntW-1:0] seen_bytes = '0;
  logic [CntW-1:0] seen_chars = '0;
  logic            failed     = 1'b0;
  logic [RegW-1:0] lim_bytes  = MaxBytesReset;
  logic [RegW-1:0] lim_chars  = MaxCharsReset;

  logic       expected_ok [$];
  logic       want_ok;
  logic [7:0] str_q [$];
  int         errors      = 0;
  bit         src_gaps    = 1'b1;
  bit         sink_stalls = 1'b1;
  bit         hold_req    = 1'b0;

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void close_char();
    logic allowed;
    allowed = 1'b0;
    if (seqlen == SeqOne)
      allowed = (acc >= 16'h0041 && acc <= 16'h005A) || (acc >= 16'h0061 && acc <= 16'h007A) ||
                (acc >= 16'h0030 && acc <= 16'h0039);
    else if (seqlen == SeqThree)
      allowed = acc >= HangulFirst && acc <= HangulLast;
    if (!allowed) failed = 1'b1;
    if (seen_chars < CntMax) seen_chars = seen_chars + 1'b1;
    acc = '0;
    seqlen = SeqNone;
  endfunction

  // advance the decoder by one byte; returns 1 with the verdict when the string ends
  function automatic bit decode_byte(input logic [7:0] b, input logic is_last, output logic ok);
    ok = 1'b0;
    if (seen_bytes < CntMax) seen_bytes = seen_bytes + 1'b1;
    if (pend == 2'd0) begin
      if (!b[7]) begin
        acc = {8'h00, b};
        seqlen = SeqOne;
        close_char();
      end else if (b[7:5] == 3'b110) begin
        acc = {11'h000, b[4:0]};
        seqlen = SeqTwo;
        pend = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc = {12'h000, b[3:0]};
        seqlen = SeqThree;
        pend = 2'd2;
      end else begin
        failed = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      // drop the broken sequence, restart at the next byte
      failed = 1'b1;
      pend = 2'd0;
      acc = '0;
      seqlen = SeqNone;
    end else begin
      acc = {acc[AccW-7:0], b[5:0]};
      pend = pend - 2'd1;
      if (pend == 2'd0) close_char();
    end
    if (!is_last) return 1'b0;
    ok = !failed && pend == 2'd0 && seen_chars != '0 &&
         seen_bytes <= {1'b0, lim_bytes} && seen_chars <= {1'b0, lim_chars};
    pend = 2'd0;
    acc = '0;
    seqlen = SeqNone;
    seen_bytes = '0;
    seen_chars = '0;
    failed = 1'b0;
    return 1'b1;
  endfunction

  function automatic void push_cont(input int n);
    repeat (n) str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
  endfunction

  function automatic void push_hangul();
    logic [15:0] cp;
    cp = 16'($urandom_range(HangulFirst, HangulLast));
    str_q.push_back({4'hE, cp[15:12]});
    str_q.push_back({2'b10, cp[11:6]});
    str_q.push_back({2'b10, cp[5:0]});
  endfunction

  task automatic make_string(input int nch, input bit noisy);
    str_q.delete();
    repeat (nch) begin
      if (noisy && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 7))
          0: str_q.push_back(8'($urandom_range(0, 255)));
          1: str_q.push_back(8'($urandom_range(0, 127)));
          2: begin
            str_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            push_cont(1);
          end
          3: begin
            // three-byte lead cut short
            str_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            push_cont(1);
          end
          4: begin
            str_q.push_back(8'($urandom_range(8'hF0, 8'hFF)));
            push_cont(3);
          end
          5: push_cont(1);
          6: begin
            str_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            push_cont(2);
          end
          default: begin
            str_q.push_back(8'hEA);
            str_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
          end
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    str_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
          2, 3:    str_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
          4, 5:    str_q.push_back(8'($urandom_range(8'h30, 8'h39)));
          default: push_hangul();
        endcase
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_last, input bit typed,
                           input logic typed_ok);
    logic ok;
    int   gap;
    byte_in.valid      <= 1'b1;
    byte_in.byte_value <= b;
    byte_in.last_byte  <= is_last;
    do @(posedge clk); while (!byte_in.ready);
    if (decode_byte(b, is_last, ok)) expected_ok.push_back(typed ? typed_ok : ok);
    gap = src_gaps ? idle_len() : 0;
    if (gap > 0) begin
      byte_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++)
      send_byte(str_q[i], i == str_q.size() - 1, 1'b0, 1'b0);
  endtask

  task automatic random_strings(input int budget);
    int sent;
    int nch;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 8)
        nch = $urandom_range(1, 6);
      else
        nch = $urandom_range(1, (lim_chars > 40) ? 42 : int'(lim_chars) + 2);
      make_string(nch, $urandom_range(0, 9) < 3);
      send_string();
      sent += str_q.size();
    end
  endtask

  // stop sending and wait for every outstanding verdict
  task automatic drain();
    int waited;
    waited = 0;
    byte_in.valid <= 1'b0;
    while (expected_ok.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (expected_ok.size() != 0) begin
      $display("%0t: %0d expected verdicts never arrived", $time, expected_ok.size());
      errors++;
      expected_ok.delete();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_limits(input logic [RegW-1:0] nb, input logic [RegW-1:0] nc);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_BYTES;
    cfg_data  <= nb;
    @(posedge clk);
    cfg_index <= REG_MAX_CHARS;
    cfg_data  <= nc;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_bytes = nb;
    lim_chars = nc;
  endtask

  // verdict side: random stalls, plus one long hold on request
  initial begin
    int stall;
    int hold;
    stall = 0;
    hold  = 0;
    result_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        result_out.ready <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        result_out.ready <= 1'b0;
        stall--;
      end else begin
        result_out.ready <= 1'b1;
        if (sink_stalls) stall = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready) begin
      if (expected_ok.size() == 0) begin
        $display("%0t: verdict %0b with none expected", $time, result_out.string_ok);
        errors++;
      end else begin
        want_ok = expected_ok.pop_front();
        if (result_out.string_ok !== want_ok) begin
          $display("%0t: string_ok mismatch, expected %0b, got %0b", $time, want_ok,
                   result_out.string_ok);
          errors++;
        end
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_MAX_BYTES;
    cfg_data           <= '0;
    byte_in.valid      <= 1'b0;
    byte_in.byte_value <= '0;
    byte_in.last_byte  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumRows; i++)
      send_byte(DirRows[i].value, DirRows[i].is_last, 1'b1, DirRows[i].ok);

    // 30 Hangul syllables hit both reset limits exactly; 31 letters exceed max_chars
    str_q.delete();
    repeat (30) push_hangul();
    send_string();
    str_q.delete();
    repeat (31) str_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    send_string();

    random_strings(15);

    // hold verdicts while short strings keep coming, so the input stalls
    src_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (8) begin
      make_string($urandom_range(1, 2), 1'b0);
      send_string();
    end
    src_gaps = 1'b1;
    random_strings(15);
    drain();

    // no idling on either side
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    random_strings(15);
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    drain();

    write_limits(8'd255, 8'd255);
    // one byte past the counter ceiling, over both limits
    str_q.delete();
    repeat (257) str_q.push_back(8'($urandom_range(8'h30, 8'h39)));
    send_string();
    random_strings(15);
    drain();

    write_limits(8'd1, 8'd1);
    random_strings(10);
    drain();

    // a zero limit rejects every string
    write_limits(8'd0, 8'd255);
    random_strings(10);
    drain();

    repeat (3) begin
      write_limits(8'($urandom_range(1, 40)), 8'($urandom_range(1, 20)));
      random_strings(10);
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
